### hdl/assert_macros.svh
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

### hdl/ttf_pkg.sv
package ttf_pkg;
   localparam int PosW   = 16;
   localparam int DeltaW = 17;
   localparam int ProdW  = 34;
   localparam int VecW   = 35;
   localparam int MagW   = 24;
   localparam int MulW   = 25;
   localparam int SqW    = 50;
   localparam int RadW   = 62;
   localparam int RootW  = 31;
   localparam int NumW   = 45;
   localparam int QuoW   = 16;
   localparam int FracW  = 20;
   localparam logic [3:0]  MulLast = 4'd13;
   localparam logic [3:0]  SqLast  = 4'd2;
   localparam logic [QuoW-1:0] UnitQ14 = 16'd16384;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_MULW, ST_PREP, ST_SHIFT, ST_SQ, ST_SQW,
      ST_SQS, ST_SQRT, ST_DVS, ST_DIVW, ST_FIN
   } state_type;
endpackage

### hdl/ttf_mul.sv
module ttf_mul import ttf_pkg::*; (
   input  logic                        clock,
   input  logic signed [MulW-1:0]      op_a,
   input  logic signed [MulW-1:0]      op_b,
   output logic signed [2*MulW-1:0]    prod
);
   logic signed [2*MulW-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   assign prod = prod_ff;
endmodule

### hdl/ttf_sqrt.sv
module ttf_sqrt import ttf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RadW-1:0]   radicand,
   output logic              done,
   output logic [RootW-1:0]  root
);
   logic [RadW-1:0] x_ff, x_in;
   logic [RadW:0]   res_ff, res_in;
   logic [RadW:0]   bit_ff, bit_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [RadW+1:0] trial;

   // one result bit per step, two radicand bits per step
   always_comb begin
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = radicand;
         res_in  = '0;
         bit_in  = {1'b1, {RadW{1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({2'b00, x_ff} >= trial) begin
            x_in   = x_ff - trial[RadW-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign root = res_ff[RootW-1:0];
endmodule

### hdl/ttf_div.sv
module ttf_div import ttf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NumW-1:0]   numer,
   input  logic [RootW-1:0]  denom,
   output logic              done,
   output logic [QuoW-1:0]   quot
);
   localparam int DvsW = RootW + QuoW - 1;

   logic [NumW-1:0] rem_ff, rem_in;
   logic [DvsW-1:0] dvs_ff, dvs_in;
   logic [QuoW-1:0] q_ff, q_in;
   logic [3:0]      cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic            ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      ge      = {{(DvsW-NumW){1'b0}}, rem_ff} >= dvs_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = numer;
         dvs_in  = {denom, {(QuoW-1){1'b0}}};
         q_in    = '0;
         cnt_in  = 4'(QuoW-1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - dvs_ff[NumW-1:0];
         end
         q_in   = {q_ff[QuoW-2:0], ge};
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff - 4'd1;
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

### hdl/triangle_tangent_frame.sv
// Vertex requests one and two of a triangle are only captured into the held vertex registers.
// After the third, the shared multiplier forms det and the vectors, then per vector come prep,
// shift, square, root and three divides, then a final step; a zero det or vector goes prep to final.
// No new request is taken until the final step has loaded the frame, which waits out output
// stalls; the pace is set by the shared multiplier, the bit-serial root and the bit-serial divider.
// Reset (synchronous, active high) clears held vertices, slot and all handshakes.
module triangle_tangent_frame import ttf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // pos_x, pos_y, pos_z, tex_u, tex_v
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // tangent_x/y/z, bitangent_x/y/z
   output logic         rsp_tuser    // degenerate
);
`include "assert_macros.svh"

   state_type state_ff, state_in;

   // held vertices of the current triangle
   logic [PosW-1:0] held_pos_ff [6];
   logic [PosW-1:0] held_tex_ff [4];
   logic [1:0]      slot_ff;

   // deltas of the triangle being worked on
   logic signed [DeltaW-1:0] dp1_ff [3];
   logic signed [DeltaW-1:0] dp2_ff [3];
   logic signed [DeltaW-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;

   // raw products, det and vectors
   logic [3:0]               cnt_ff;
   logic                     mv_ff, sq_ff;
   logic [3:0]               idx_ff;
   logic signed [ProdW-1:0]  first_ff;
   logic signed [VecW-1:0]   det_ff;
   logic signed [VecW-1:0]   vec_ff [6];   // t0,b0,t1,b1,t2,b2

   // normalization
   logic                     vsel_ff;
   logic [VecW-1:0]          a_ff [3];
   logic [VecW-1:0]          m_ff;
   logic [SqW-1:0]           sum_ff;
   logic [RootW-1:0]         r_ff;
   logic [1:0]               ci_ff;
   logic [PosW-1:0]          res_ff [6];
   logic                     degen_ff;

   logic                     rsp_valid_ff;
   logic [95:0]              rsp_data_ff;
   logic                     rsp_user_ff;

   // control
   logic req_acc, out_free, fin_load, mul_go, sq_go;
   logic sq_start, sq_done, dv_start, dv_done;

   // input fields
   logic [PosW-1:0] in_pos [3];
   logic [PosW-1:0] in_u, in_v;

   // multiplier
   logic signed [MulW-1:0]   op_a, op_b;
   logic signed [2*MulW-1:0] prod;
   logic [3:0]               sub;
   logic [1:0]               comp;

   // vector selection and magnitudes
   logic signed [VecW-1:0]   c_sel [3];
   logic [VecW-1:0]          c_abs [3];
   logic [VecW-1:0]          c_max;
   logic                     det_zero, det_neg;

   logic [RootW-1:0]         root;
   logic [QuoW-1:0]          quot, n_sat;
   logic [NumW-1:0]          numer;
   logic signed [VecW-1:0]   diff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_pos[i] = req_tdata[16*i +: 16];
      end
      in_u = req_tdata[63:48];
      in_v = req_tdata[79:64];
   end

   assign det_zero = (det_ff == '0);
   assign det_neg  = det_ff[VecW-1];

   always_comb begin
      c_max = '0;
      for (int i = 0; i < 3; i++) begin
         c_sel[i] = vsel_ff ? vec_ff[2*i+1] : vec_ff[2*i];
         c_abs[i] = c_sel[i][VecW-1] ? VecW'(-c_sel[i]) : VecW'(c_sel[i]);
         if (c_abs[i] > c_max) begin
            c_max = c_abs[i];
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_acc && slot_ff[1]) state_in = ST_MUL;
         ST_MUL:   if (cnt_ff == MulLast) state_in = ST_MULW;
         ST_MULW:  state_in = ST_PREP;
         ST_PREP:  state_in = (det_zero || c_max == '0) ? ST_FIN : ST_SHIFT;
         ST_SHIFT: if (m_ff[VecW-1:MagW] == '0 && m_ff[MagW-1]) state_in = ST_SQ;
         ST_SQ:    if (cnt_ff == SqLast) state_in = ST_SQW;
         ST_SQW:   state_in = ST_SQS;
         ST_SQS:   state_in = ST_SQRT;
         ST_SQRT:  if (sq_done) state_in = ST_DVS;
         ST_DVS:   state_in = ST_DIVW;
         ST_DIVW: begin
            if (dv_done) begin
               if (ci_ff != 2'd2) state_in = ST_DVS;
               else if (!vsel_ff) state_in = ST_PREP;
               else state_in = ST_FIN;
            end
         end
         ST_FIN:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE) && !reset;
      mul_go     = (state_ff == ST_MUL);
      sq_go      = (state_ff == ST_SQ);
      sq_start   = (state_ff == ST_SQS);
      dv_start   = (state_ff == ST_DVS);
      fin_load   = (state_ff == ST_FIN) && out_free;
   end

   assign req_acc  = req_tvalid && req_tready;
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ------------------------------------------------------------------
   // Shared multiplier operand select
   // ------------------------------------------------------------------
   always_comb begin
      sub  = cnt_ff - 4'd2;
      comp = sub[3:2];
      op_a = '0;
      op_b = '0;
      if (sq_go) begin
         op_a = {1'b0, a_ff[cnt_ff[1:0]][MagW-1:0]};
         op_b = {1'b0, a_ff[cnt_ff[1:0]][MagW-1:0]};
      end else if (cnt_ff == 4'd0) begin
         op_a = MulW'(du1_ff);
         op_b = MulW'(dv2_ff);
      end else if (cnt_ff == 4'd1) begin
         op_a = MulW'(du2_ff);
         op_b = MulW'(dv1_ff);
      end else if (mul_go) begin
         case (sub[1:0])
            2'd0: begin op_a = MulW'(dv2_ff); op_b = MulW'(dp1_ff[comp]); end
            2'd1: begin op_a = MulW'(dv1_ff); op_b = MulW'(dp2_ff[comp]); end
            2'd2: begin op_a = MulW'(du1_ff); op_b = MulW'(dp2_ff[comp]); end
            default: begin op_a = MulW'(du2_ff); op_b = MulW'(dp1_ff[comp]); end
         endcase
      end
   end

   ttf_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   ttf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand ({sum_ff, 12'b0}),
      .done     (sq_done),
      .root     (root)
   );

   // rounded quotient numerator: a * 2^20 + r/2
   assign numer = {1'b0, a_ff[ci_ff][MagW-1:0], {FracW{1'b0}}}
                + {{(NumW-RootW+1){1'b0}}, r_ff[RootW-1:1]};

   ttf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (dv_start),
      .numer (numer),
      .denom (r_ff),
      .done  (dv_done),
      .quot  (quot)
   );

   assign n_sat = (quot > UnitQ14) ? UnitQ14 : quot;
   assign diff  = VecW'(first_ff) - VecW'($signed(prod[ProdW-1:0]));

   // ------------------------------------------------------------------
   // Datapath registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      // vertex capture and deltas
      if (req_acc && !slot_ff[1]) begin
         for (int i = 0; i < 3; i++) begin
            held_pos_ff[slot_ff[0] ? 3+i : i] <= in_pos[i];
         end
         held_tex_ff[slot_ff[0] ? 2 : 0] <= in_u;
         held_tex_ff[slot_ff[0] ? 3 : 1] <= in_v;
      end
      if (req_acc && slot_ff[1]) begin
         for (int i = 0; i < 3; i++) begin
            dp1_ff[i] <= DeltaW'($signed(held_pos_ff[3+i])) - DeltaW'($signed(held_pos_ff[i]));
            dp2_ff[i] <= DeltaW'($signed(in_pos[i])) - DeltaW'($signed(held_pos_ff[i]));
         end
         du1_ff <= DeltaW'($signed(held_tex_ff[2])) - DeltaW'($signed(held_tex_ff[0]));
         dv1_ff <= DeltaW'($signed(held_tex_ff[3])) - DeltaW'($signed(held_tex_ff[1]));
         du2_ff <= DeltaW'($signed(in_u)) - DeltaW'($signed(held_tex_ff[0]));
         dv2_ff <= DeltaW'($signed(in_v)) - DeltaW'($signed(held_tex_ff[1]));
         vsel_ff  <= 1'b0;
         degen_ff <= 1'b0;
      end

      // step counter for multiplier passes
      if (mul_go || sq_go) begin
         cnt_ff <= cnt_ff + 4'd1;
      end else begin
         cnt_ff <= '0;
      end
      idx_ff <= cnt_ff;
      sq_ff  <= sq_go;

      // product accumulation, in the cycle after issue
      if (mv_ff) begin
         if (sq_ff) begin
            sum_ff <= sum_ff + prod[SqW-1:0];
         end else if (!idx_ff[0]) begin
            first_ff <= prod[ProdW-1:0];
         end else if (idx_ff[3:1] == 3'd0) begin
            det_ff <= diff;
         end else begin
            vec_ff[idx_ff[3:1] - 3'd1] <= diff;
         end
      end

      if (state_ff == ST_PREP) begin
         a_ff   <= c_abs;
         m_ff   <= c_max;
         sum_ff <= '0;
         ci_ff  <= '0;
         if (det_zero || c_max == '0) begin
            degen_ff <= 1'b1;
         end
      end

      // bring the largest magnitude into [2^23, 2^24)
      if (state_ff == ST_SHIFT) begin
         if (m_ff[VecW-1:MagW] != '0) begin
            m_ff <= m_ff >> 1;
            for (int i = 0; i < 3; i++) a_ff[i] <= a_ff[i] >> 1;
         end else if (!m_ff[MagW-1]) begin
            m_ff <= m_ff << 1;
            for (int i = 0; i < 3; i++) a_ff[i] <= a_ff[i] << 1;
         end
      end

      if (state_ff == ST_SQRT && sq_done) begin
         r_ff <= root;
      end

      if (state_ff == ST_DIVW && dv_done) begin
         res_ff[vsel_ff ? 3'(ci_ff) + 3'd3 : 3'(ci_ff)] <=
            (c_sel[ci_ff][VecW-1] ^ det_neg) ? (~n_sat + 16'd1) : n_sat;
         ci_ff <= ci_ff + 2'd1;
         if (ci_ff == 2'd2) begin
            vsel_ff <= 1'b1;
         end
      end

      if (fin_load) begin
         for (int i = 0; i < 6; i++) begin
            rsp_data_ff[16*i +: 16] <= degen_ff ? '0 : res_ff[i];
         end
         rsp_user_ff <= degen_ff;
      end

      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         mv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) held_pos_ff[i] <= '0;
         for (int i = 0; i < 4; i++) held_tex_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         mv_ff    <= mul_go || sq_go;
         if (req_acc) begin
            slot_ff <= slot_ff[1] ? 2'd0 : slot_ff + 2'd1;
         end
         if (fin_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `ASSERT_PROP(a_degen_zero, clock, reset, (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == '0))
   `ASSERT_NEVER(a_slot_range, clock, reset, slot_ff == 2'd3)
   `ASSERT_PROP(a_unit_range, clock, reset, rsp_valid_ff |-> ($signed(rsp_data_ff[15:0]) <= 16384 && $signed(rsp_data_ff[15:0]) >= -16384))
   `ASSERT_PROP(a_busy_stall, clock, reset, (state_ff != ST_IDLE) |-> !req_tready)
endmodule

### sim/triangle_tangent_frame_checker.sv
`timescale 1ns / 1ps

module triangle_tangent_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          frames_pending,
   output int          frames_seen,
   output int          degenerate_seen
);

   typedef struct packed {
      logic        degenerate;
      logic [95:0] vectors;
   } frame_type;

   frame_type   frame_queue[$];
   logic [15:0] vtx_pos[6];
   logic [15:0] vtx_uv[4];
   logic [1:0]  vtx_held;

   function automatic longint isqrt(longint unsigned x);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x -= res + bit_v;
            res = (res >> 1) + bit_v;
         end else begin
            res >>= 1;
         end
         bit_v >>= 2;
      end
      return res;
   endfunction

   // Unit vector in Q1.14; returns 0 on a zero vector.
   function automatic bit unit_vector(input longint c[3], output logic [47:0] o);
      longint unsigned a[3], m, sum, r, n;
      int s;
      m = 0;
      o = '0;
      for (int i = 0; i < 3; i++) begin
         a[i] = (c[i] < 0) ? -c[i] : c[i];
         if (a[i] > m) m = a[i];
      end
      if (m == 0) return 0;
      if (m >= (64'd1 << 24)) begin
         s = 0;
         while ((m >> s) >= (64'd1 << 24)) s++;
         for (int i = 0; i < 3; i++) a[i] >>= s;
      end else begin
         while (m < (64'd1 << 23)) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) a[i] <<= 1;
         end
      end
      sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      r = isqrt(sum << 12);
      for (int i = 0; i < 3; i++) begin
         n = ((a[i] << 20) + r / 2) / r;
         if (n > 16384) n = 16384;
         o[16*i +: 16] = (c[i] < 0) ? 16'(-n) : 16'(n);
      end
      return 1;
   endfunction

   function automatic frame_type tangent_frame(input logic [79:0] d);
      longint dp1[3], dp2[3], t[3], b[3], u0, v0, du1, dv1, du2, dv2, det;
      logic [47:0] tu, bu;
      bit ok;
      frame_type f;
      for (int i = 0; i < 3; i++) begin
         dp1[i] = longint'($signed(vtx_pos[3+i])) - longint'($signed(vtx_pos[i]));
         dp2[i] = longint'($signed(d[16*i +: 16])) - longint'($signed(vtx_pos[i]));
      end
      u0 = longint'($signed(vtx_uv[0]));
      v0 = longint'($signed(vtx_uv[1]));
      du1 = longint'($signed(vtx_uv[2])) - u0;
      dv1 = longint'($signed(vtx_uv[3])) - v0;
      du2 = longint'($signed(d[63:48])) - u0;
      dv2 = longint'($signed(d[79:64])) - v0;
      det = du1 * dv2 - du2 * dv1;
      for (int i = 0; i < 3; i++) begin
         t[i] = dv2 * dp1[i] - dv1 * dp2[i];
         b[i] = du1 * dp2[i] - du2 * dp1[i];
         if (det < 0) begin
            t[i] = -t[i];
            b[i] = -b[i];
         end
      end
      ok = (det != 0);
      if (ok) ok = unit_vector(t, tu);
      if (ok) ok = unit_vector(b, bu);
      f.vectors = ok ? {bu, tu} : '0;
      f.degenerate = !ok;
      return f;
   endfunction

   assign frames_pending = frame_queue.size();

   always @(posedge clock) begin
      frame_type want;
      if (reset) begin
         vtx_held <= 0;
         fail_count <= 0;
         frames_seen <= 0;
         degenerate_seen <= 0;
         foreach (vtx_pos[i]) vtx_pos[i] <= '0;
         foreach (vtx_uv[i]) vtx_uv[i] <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            if (vtx_held < 2) begin
               for (int i = 0; i < 3; i++) vtx_pos[vtx_held*3+i] <= req_tdata[16*i +: 16];
               vtx_uv[vtx_held*2]   <= req_tdata[63:48];
               vtx_uv[vtx_held*2+1] <= req_tdata[79:64];
               vtx_held <= vtx_held + 1;
            end else begin
               frame_queue.push_back(tangent_frame(req_tdata));
               vtx_held <= 0;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            frames_seen <= frames_seen + 1;
            if (rsp_tuser) degenerate_seen <= degenerate_seen + 1;
            if (frame_queue.size() == 0) begin
               $display("%0t: unexpected frame %h deg %b", $time, rsp_tdata, rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = frame_queue.pop_front();
               if (want.vectors !== rsp_tdata || want.degenerate !== rsp_tuser) begin
                  $display("%0t: frame mismatch expected %h deg %b actual %h deg %b",
                           $time, want.vectors, want.degenerate, rsp_tdata, rsp_tuser);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

### sim/triangle_tangent_frame_tb.sv
`timescale 1ns / 1ps

// Drives vertex requests in triangle order (directed corner cases, then random
// triangles of mixed scale) through three idle phases; checker predicts frames.
module triangle_tangent_frame_tb;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // pos_x, pos_y, pos_z, tex_u, tex_v
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [95:0] rsp_tdata;        // tangent_x/y/z, bitangent_x/y/z
   logic        rsp_tuser;        // degenerate
   int          fail_count, frames_pending, frames_seen, degenerate_seen;
   int          send_idle_pct = 34;
   int          recv_idle_pct = 79;
   int          vertex_count = 0;

   triangle_tangent_frame dut (.*);
   triangle_tangent_frame_checker checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Receiver stalls at random, changes at the falling edge.
   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Valid stays high into the next call; it drops only while idling.
   task automatic send_vertex(input logic [15:0] px, py, pz, tu, tv);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {tv, tu, pz, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      vertex_count++;
   endtask

   // Random vertex; scale picks small, medium or full-range coordinates.
   task automatic send_random_vertex(input int scale);
      logic [15:0] f[5];
      foreach (f[i]) begin
         case (scale)
            0: f[i] = 16'($signed($urandom_range(16)) - 8);
            1: f[i] = 16'($signed($urandom_range(2048)) - 1024);
            default: f[i] = 16'($urandom);
         endcase
      end
      send_vertex(f[0], f[1], f[2], f[3], f[4]);
   endtask

   initial begin
      int scale;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // unit right triangle, then the same with reversed winding (negative det)
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(16'h0100, 0, 0, 16'h1000, 0);
      send_vertex(0, 16'h0100, 0, 0, 16'h1000);
      send_vertex(0, 16'h0100, 0, 0, 16'h1000);
      send_vertex(16'h0100, 0, 0, 16'h1000, 0);
      send_vertex(0, 0, 0, 0, 0);
      // zero determinant: collinear UVs
      send_vertex(0, 0, 0, 0, 0);
      send_vertex(16'h0100, 16'h0200, 0, 16'h0100, 16'h0100);
      send_vertex(16'h0300, 0, 16'h0100, 16'h0200, 16'h0200);
      // nonzero det but zero-length vectors: all positions equal
      send_vertex(16'h1234, 16'h1234, 16'h1234, 0, 0);
      send_vertex(16'h1234, 16'h1234, 16'h1234, 16'h1000, 0);
      send_vertex(16'h1234, 16'h1234, 16'h1234, 0, 16'h1000);
      // field extremes: large shift path
      send_vertex(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
      send_vertex(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
      send_vertex(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      // tiny deltas: long left-shift path
      send_vertex(16'hFFFF, 0, 0, 16'hFFFF, 0);
      send_vertex(0, 16'hFFFF, 0, 0, 0);
      send_vertex(0, 0, 1, 16'hFFFF, 16'hFFFF);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 79 : 0;
         recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 34 : 0;
         for (int tri_idx = 0; tri_idx < 100; tri_idx++) begin
            scale = $urandom_range(2);
            repeat (3) send_random_vertex(scale);
         end
      end
      req_tvalid <= 0;

      fork
         wait (frames_pending == 0);
         begin
            #5ms;
            $display("Timeout waiting for frames");
         end
      join_any
      repeat (300) @(posedge clock);
      $display("Covered %0d vertex requests, %0d frames checked (%0d degenerate)",
               vertex_count, frames_seen, degenerate_seen);
      if (fail_count == 0 && frames_pending == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### files.f
+incdir+hdl
hdl/ttf_pkg.sv
hdl/ttf_mul.sv
hdl/ttf_sqrt.sv
hdl/ttf_div.sv
hdl/triangle_tangent_frame.sv
sim/triangle_tangent_frame_checker.sv
sim/triangle_tangent_frame_tb.sv
